>>> rtl/core/sui_pkg.sv
// Shared types and constants of the stack instruction unit.
package sui_pkg;

    localparam int          CFG_W        = 13;
    localparam logic [12:0] MEM_SIZE_RST = 13'd4096;
    localparam int          REG_COUNT    = 15;
    localparam logic [3:0]  SP_IDX       = 4'd4;
    localparam logic [63:0] QUAD_STEP    = 64'd8;

    localparam logic [2:0] MODE_CALL = 3'd0;
    localparam logic [2:0] MODE_RET  = 3'd1;
    localparam logic [2:0] MODE_PUSH = 3'd2;
    localparam logic [2:0] MODE_POP  = 3'd3;
    localparam logic [2:0] MODE_LOAD = 3'd4;

    typedef enum logic [2:0] {
        OP_CALL,
        OP_RET,
        OP_PUSH,
        OP_POP,
        OP_LOAD,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        st;
        logic        ld;
        logic [3:0]  reg_a;
        logic [63:0] val_c;
        logic [63:0] val_p;
    } t_item;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

>>> rtl/core/sui_front.sv
// Front end: accepts input items, classifies them and queues them for execution.
module sui_front
    import sui_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_reg_a,
    input  logic [63:0] i_val_c,
    input  logic [63:0] i_val_p,
    input  logic        i_hold,
    input  logic        i_pop,
    output logic        o_head_valid,
    output t_item       o_head
);

    localparam int QD = 2;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    t_item          r_q [QD];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    t_item          dec;
    logic           push;

    always_comb begin
        dec       = '0;
        dec.reg_a = i_reg_a;
        dec.val_c = i_val_c;
        dec.val_p = i_val_p;
        case (i_mode)
            MODE_CALL: begin
                dec.op = OP_CALL;
                dec.st = 1'b1;
            end
            MODE_RET: begin
                dec.op = OP_RET;
                dec.ld = 1'b1;
            end
            MODE_PUSH: begin
                dec.op = OP_PUSH;
                dec.st = 1'b1;
            end
            MODE_POP: begin
                dec.op = OP_POP;
                dec.ld = 1'b1;
            end
            MODE_LOAD: begin
                dec.op = OP_LOAD;
            end
            default: begin
                dec.op = OP_BAD;
            end
        endcase
    end

    assign o_in_stall   = (r_cnt == CW'(QD)) || i_hold;
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CW'(QD) && !i_pop |=> r_cnt == CW'(QD))
        else $error("queue count moved past full");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from an empty queue");

endmodule

>>> rtl/core/sui_mem.sv
// Byte-addressed stack memory in eight byte banks with an unaligned quad port.
module sui_mem
    import sui_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_mem_ctl                             i_ctl,
    input  logic [$clog2((MEM_BYTES+7)/8)-1:0]   i_row,
    input  logic [2:0]                           i_off,
    input  logic [63:0]                          i_wdata,
    output logic [63:0]                          o_rdata,
    output logic                                 o_busy
);

    localparam int ROWS = (MEM_BYTES + 7) / 8;
    localparam int RW   = $clog2(ROWS);

    logic          r_busy;
    logic [RW-1:0] r_clr;
    logic [2:0]    r_off;
    logic [127:0]  wdbl;
    logic [63:0]   wrot;
    logic [63:0]   rd_cat;
    logic [127:0]  rdbl;

    // Byte k of the quad lives in bank (off + k) mod 8.
    assign wdbl    = {i_wdata, i_wdata} << {i_off, 3'b000};
    assign wrot    = wdbl[127:64];
    assign rdbl    = {rd_cat, rd_cat} >> {r_off, 3'b000};
    assign o_rdata = rdbl[63:0];
    assign o_busy  = r_busy;

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [7:0]    mem [ROWS];
        logic [7:0]    r_byte;
        logic [RW-1:0] row;

        // Banks below the start offset hold the bytes that spill into the next row.
        assign row = (3'(b) < i_off) ? i_row + RW'(1) : i_row;
        assign rd_cat[8*b +: 8] = r_byte;

        always_ff @(posedge i_clk) begin
            if (r_busy) begin
                mem[r_clr] <= 8'h00;
            end else if (i_ctl.wr) begin
                mem[row] <= wrot[8*b +: 8];
            end
            if (i_ctl.rd) begin
                r_byte <= mem[row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_off <= i_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + RW'(1);
            if (r_clr == RW'(ROWS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_clr) == RW'(ROWS - 1))
        else $error("clearing pass ended early");

endmodule

>>> rtl/core/sui_back.sv
// Back end: register file, stack pointer and program counter, execution and result register.
module sui_back
    import sui_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [CFG_W-1:0]                     i_cfg_data,
    input  logic                                 i_head_valid,
    input  t_item                                i_head,
    output logic                                 o_pop,
    output t_mem_ctl                             o_mem_ctl,
    output logic [$clog2((MEM_BYTES+7)/8)-1:0]   o_mem_row,
    output logic [2:0]                           o_mem_off,
    output logic [63:0]                          o_mem_wdata,
    input  logic [63:0]                          i_mem_rdata,
    input  logic                                 i_mem_busy,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_ok,
    output logic [63:0]                          o_next_pc,
    output logic [63:0]                          o_stack_pointer
);

    localparam int AWID = $clog2(MEM_BYTES);
    localparam int LW   = (AWID + 1 > CFG_W) ? AWID + 1 : CFG_W;
    localparam int ROWS = (MEM_BYTES + 7) / 8;
    localparam int RW   = $clog2(ROWS);

    typedef enum logic [1:0] {
        ST_ISSUE  = 2'b01,
        ST_FINISH = 2'b10
    } t_bstate;

    t_bstate           r_state;
    logic [63:0]       r_regs [REG_COUNT];
    logic [63:0]       r_pc;
    logic [CFG_W-1:0]  r_mem_size;
    t_item             r_ex;
    logic              r_inb;
    logic              r_out_valid;
    logic              r_ok;
    logic [63:0]       r_out_pc;
    logic [63:0]       r_out_sp;

    logic [63:0] sp;
    logic [63:0] sp_dec;
    logic [63:0] sp_inc;
    logic [63:0] addr;
    logic [63:0] rd_a;
    logic [LW-1:0] size_ext;
    logic [LW-1:0] lim;
    logic        inb;
    logic        issue;
    logic        finish;
    logic [63:0] ld_val;
    logic [63:0] n_pc;
    logic [63:0] n_sp;
    logic        n_ok;
    logic        rf_we;
    logic [63:0] rf_val;

    assign sp     = r_regs[SP_IDX];
    assign sp_dec = sp - QUAD_STEP;
    assign sp_inc = sp + QUAD_STEP;

    assign issue  = (r_state == ST_ISSUE) && i_head_valid && !i_mem_busy;
    assign finish = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);
    assign o_pop  = issue;

    assign addr = i_head.st ? sp_dec : sp;
    assign rd_a = (i_head.reg_a < 4'(REG_COUNT)) ? r_regs[i_head.reg_a] : 64'd0;

    // Sizes above the physical memory act as the physical size; the check never wraps.
    assign size_ext = LW'(r_mem_size);
    assign lim      = (size_ext > LW'(MEM_BYTES)) ? LW'(MEM_BYTES) : size_ext;
    assign inb      = (addr[63:LW] == '0)
                   && (({1'b0, addr[LW-1:0]} + (LW+1)'(8)) <= {1'b0, lim});

    assign o_mem_ctl.wr = issue && i_head.st && inb;
    assign o_mem_ctl.rd = issue && i_head.ld && inb;
    assign o_mem_row    = addr[RW+2:3];
    assign o_mem_off    = addr[2:0];
    // Pushing the stack pointer stores its decremented value.
    assign o_mem_wdata  = (i_head.op == OP_CALL) ? i_head.val_p :
                          (i_head.reg_a == SP_IDX) ? sp_dec : rd_a;

    assign ld_val = r_inb ? i_mem_rdata : 64'd0;

    always_comb begin
        n_pc   = r_pc;
        n_sp   = sp;
        n_ok   = r_inb;
        rf_we  = 1'b0;
        rf_val = ld_val;
        case (r_ex.op)
            OP_CALL: begin
                n_sp = sp_dec;
                n_pc = r_ex.val_c;
            end
            OP_RET: begin
                n_pc = ld_val;
                n_sp = sp_inc;
            end
            OP_PUSH: begin
                n_pc = r_ex.val_p;
                n_sp = sp_dec;
            end
            OP_POP: begin
                n_pc  = r_ex.val_p;
                n_sp  = sp_inc;
                rf_we = (r_ex.reg_a != SP_IDX) && (r_ex.reg_a < 4'(REG_COUNT));
            end
            OP_LOAD: begin
                n_ok   = 1'b1;
                rf_val = r_ex.val_c;
                if (r_ex.reg_a == SP_IDX) begin
                    n_sp = r_ex.val_c;
                end else begin
                    rf_we = (r_ex.reg_a < 4'(REG_COUNT));
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ex  <= i_head;
            r_inb <= inb;
        end
        if (finish) begin
            r_ok     <= n_ok;
            r_out_pc <= n_pc;
            r_out_sp <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ISSUE;
            r_pc        <= '0;
            r_mem_size  <= MEM_SIZE_RST;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_mem_size <= i_cfg_data;
            end
            case (r_state)
                ST_ISSUE: begin
                    if (issue) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (finish) begin
                        r_state <= ST_ISSUE;
                    end
                end
                default: begin
                    r_state <= ST_ISSUE;
                end
            endcase
            if (finish) begin
                r_pc           <= n_pc;
                r_regs[SP_IDX] <= n_sp;
                // The general write never targets the stack pointer.
                if (rf_we) begin
                    r_regs[r_ex.reg_a] <= rf_val;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_next_pc       = r_out_pc;
    assign o_stack_pointer = r_out_sp;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && r_out_valid && i_out_stall |=> r_state == ST_FINISH)
        else $error("item retired while the result register was stalled");

    a_call_moves_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish && r_ex.op == OP_CALL |=> r_regs[SP_IDX] == $past(r_regs[SP_IDX]) - QUAD_STEP)
        else $error("call did not lower the stack pointer by one quad");

    a_no_access_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mem_busy |-> !o_pop && !o_mem_ctl.rd && !o_mem_ctl.wr)
        else $error("memory access during the clearing pass");

endmodule

>>> rtl/core/stack_instruction_unit_core.sv
// Top level of the stack instruction unit: front end, queue, back end and stack memory.
// The back end takes one item at a time: it issues an item and finishes it around the
// registered read of the byte-bank memory before it takes the next; output stall holds it.
// Reset: synchronous, active low; registers and pc clear at once, then a clearing pass
// zeroes the memory at one row a cycle with input stalled.
module stack_instruction_unit_core
    import sui_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_mode,
    input  logic [3:0]        i_reg_a,
    input  logic [63:0]       i_val_c,
    input  logic [63:0]       i_val_p,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_ok,
    output logic [63:0]       o_next_pc,
    output logic [63:0]       o_stack_pointer,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int RW = $clog2((MEM_BYTES + 7) / 8);

    logic          head_valid;
    t_item         head;
    logic          pop;
    t_mem_ctl      mem_ctl;
    logic [RW-1:0] mem_row;
    logic [2:0]    mem_off;
    logic [63:0]   mem_wdata;
    logic [63:0]   mem_rdata;
    logic          mem_busy;

    assign o_cfg_ready = 1'b1;

    sui_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_reg_a      (i_reg_a),
        .i_val_c      (i_val_c),
        .i_val_p      (i_val_p),
        .i_hold       (mem_busy),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    sui_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_row   (mem_row),
        .i_off   (mem_off),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    sui_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_mem_ctl       (mem_ctl),
        .o_mem_row       (mem_row),
        .o_mem_off       (mem_off),
        .o_mem_wdata     (mem_wdata),
        .i_mem_rdata     (mem_rdata),
        .i_mem_busy      (mem_busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_next_pc       (o_next_pc),
        .o_stack_pointer (o_stack_pointer)
    );

endmodule

>>> tb/stack_instruction_unit_checker.sv
// Checker for the stack instruction unit: predicts each result and compares it on the output.
module stack_instruction_unit_checker
    import sui_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [2:0]        i_mode,
    input  logic [3:0]        i_reg_a,
    input  logic [63:0]       i_val_c,
    input  logic [63:0]       i_val_p,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_ok,
    input  logic [63:0]       i_next_pc,
    input  logic [63:0]       i_stack_pointer,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        ok;
        logic [63:0] next_pc;
        logic [63:0] stack_pointer;
    } t_stack_result;

    logic [63:0]      gpr [0:REG_COUNT-1];
    logic [7:0]       stack_mem [0:MEM_BYTES-1];
    logic [63:0]      pc_model;
    logic [CFG_W-1:0] mem_size_model;
    t_stack_result    expected_results [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // Keep the log short if the block is badly broken; the count still goes up.
        if (o_fail_count < 40)
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic quad_fits(input logic [63:0] addr);
        logic [63:0] lim;
        lim = (64'(mem_size_model) > 64'(MEM_BYTES)) ? 64'(MEM_BYTES) : 64'(mem_size_model);
        // Written so that an address near the top of the space cannot wrap past the check.
        return (addr <= lim) && (lim - addr >= QUAD_STEP);
    endfunction

    function automatic logic load_quad(input logic [63:0] addr, output logic [63:0] word);
        word = '0;
        if (!quad_fits(addr))
            return 1'b0;
        for (int i = 0; i < 8; i++)
            word[8*i +: 8] = stack_mem[int'(addr) + i];
        return 1'b1;
    endfunction

    function automatic logic store_quad(input logic [63:0] addr, input logic [63:0] word);
        if (!quad_fits(addr))
            return 1'b0;
        for (int i = 0; i < 8; i++)
            stack_mem[int'(addr) + i] = word[8*i +: 8];
        return 1'b1;
    endfunction

    function automatic logic [63:0] gpr_read(input logic [3:0] idx);
        return (int'(idx) < REG_COUNT) ? gpr[idx] : 64'd0;
    endfunction

    function automatic void gpr_write(input logic [3:0] idx, input logic [63:0] value);
        if (int'(idx) < REG_COUNT)
            gpr[idx] = value;
    endfunction

    function automatic t_stack_result execute_stack_op(input logic [2:0] mode,
                                                       input logic [3:0] ra,
                                                       input logic [63:0] vc,
                                                       input logic [63:0] vp);
        t_stack_result res;
        logic [63:0]   sp_old;
        logic [63:0]   word;
        logic          good;
        good   = 1'b1;
        sp_old = gpr[SP_IDX];
        case (mode)
            MODE_CALL: begin
                gpr[SP_IDX] = sp_old - QUAD_STEP;
                good        = store_quad(gpr[SP_IDX], vp);
                pc_model    = vc;
            end
            MODE_RET: begin
                good        = load_quad(sp_old, word);
                pc_model    = word;
                gpr[SP_IDX] = sp_old + QUAD_STEP;
            end
            MODE_PUSH: begin
                pc_model    = vp;
                gpr[SP_IDX] = sp_old - QUAD_STEP;
                // The register is read after the decrement, so pushing sp stores the new sp.
                good        = store_quad(gpr[SP_IDX], gpr_read(ra));
            end
            MODE_POP: begin
                pc_model = vp;
                good     = load_quad(sp_old, word);
                gpr_write(ra, word);
                gpr[SP_IDX] = sp_old + QUAD_STEP;
            end
            MODE_LOAD: begin
                gpr_write(ra, vc);
            end
            default: begin
                good = 1'b0;
            end
        endcase
        res.ok            = good;
        res.next_pc       = pc_model;
        res.stack_pointer = gpr[SP_IDX];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++)
                gpr[i] = '0;
            for (int i = 0; i < MEM_BYTES; i++)
                stack_mem[i] = '0;
            pc_model       = '0;
            mem_size_model = MEM_SIZE_RST;
            o_fail_count   = 0;
            o_checked      = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", i_next_pc, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_ok !== want.ok)
                        report_mismatch("ok", 64'(i_ok), 64'(want.ok));
                    if (i_next_pc !== want.next_pc)
                        report_mismatch("next_pc", i_next_pc, want.next_pc);
                    if (i_stack_pointer !== want.stack_pointer)
                        report_mismatch("stack_pointer", i_stack_pointer, want.stack_pointer);
                    o_checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                mem_size_model = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(execute_stack_op(i_mode, i_reg_a, i_val_c, i_val_p));
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/stack_instruction_unit_core_tb.sv
// Top of the stack instruction unit testbench: clock, reset, stimulus and verdict.
module stack_instruction_unit_core_tb
    import sui_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MEM_BYTES    = 4096;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          SEG_ITEMS    = 170;
    localparam logic [2:0]  MODE_BAD_LO  = 3'd5;
    localparam logic [2:0]  MODE_BAD_HI  = 3'd7;
    localparam logic [63:0] ALL_ONES     = '1;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [2:0]        in_mode     = '0;
    logic [3:0]        in_reg_a    = '0;
    logic [63:0]       in_val_c    = '0;
    logic [63:0]       in_val_p    = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic              res_ok;
    logic [63:0]       res_next_pc;
    logic [63:0]       res_sp;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data    = '0;

    int fail_count;
    int pending;
    int checked;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int items_sent   = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;
    int seg_items;
    logic [63:0] mem_lim = 64'd4096;

    logic [CFG_W-1:0] mem_size_plan [6] = '{13'd64, 13'd8191, 13'd0, 13'd4095, 13'd9, 13'd4096};

    stack_instruction_unit_core #(.MEM_BYTES(MEM_BYTES)) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (in_mode),
        .i_reg_a         (in_reg_a),
        .i_val_c         (in_val_c),
        .i_val_p         (in_val_p),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_ok            (res_ok),
        .o_next_pc       (res_next_pc),
        .o_stack_pointer (res_sp),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    stack_instruction_unit_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (in_mode),
        .i_reg_a         (in_reg_a),
        .i_val_c         (in_val_c),
        .i_val_p         (in_val_p),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_ok            (res_ok),
        .i_next_pc       (res_next_pc),
        .i_stack_pointer (res_sp),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rcv_idle_pct);

    // The clearing pass after reset and long receiver stalls both fit well inside the limit.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Valid stays high between back-to-back items; it drops for a sender gap and in drain.
    task automatic send_item(input logic [2:0] mode, input logic [3:0] ra,
                             input logic [63:0] vc, input logic [63:0] vp);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_reg_a <= ra;
        in_val_c <= vc;
        in_val_p <= vp;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        seg_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_mem_size(input logic [CFG_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        mem_lim = (int'(value) > MEM_BYTES) ? 64'(MEM_BYTES) : 64'(value);
        cfg_writes++;
    endtask

    // Stack program: set sp, fill a few registers, then mix calls, pushes, rets and pops.
    task automatic run_stack_program();
        logic [63:0] base;
        int          depth;
        int          steps;
        depth = 0;
        case ($urandom_range(9))
            0: base = mem_lim;
            1: base = mem_lim + 64'($urandom_range(8));
            2: base = rand64();
            3: base = 64'($urandom_range(16));
            default: base = (mem_lim >= 64'd16) ? 64'($urandom_range(int'(mem_lim), 16))
                                                 : 64'($urandom_range(16));
        endcase
        send_item(MODE_LOAD, SP_IDX, base, rand64());
        repeat ($urandom_range(3, 1))
            send_item(MODE_LOAD, 4'($urandom_range(15)), rand64(), rand64());
        steps = $urandom_range(12, 4);
        repeat (steps) begin
            if ($urandom_range(9) == 0) begin
                send_item(MODE_LOAD, 4'($urandom_range(15)), rand64(), rand64());
            end else if (depth == 0 || $urandom_range(1) == 0) begin
                if ($urandom_range(1) == 0)
                    send_item(MODE_CALL, 4'($urandom_range(15)), rand64(), rand64());
                else
                    send_item(MODE_PUSH, 4'($urandom_range(15)), rand64(), rand64());
                depth++;
            end else begin
                if ($urandom_range(1) == 0)
                    send_item(MODE_RET, 4'($urandom_range(15)), rand64(), rand64());
                else
                    send_item(MODE_POP, 4'($urandom_range(15)), rand64(), rand64());
                depth--;
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        snd_idle_pct = 37;
        rcv_idle_pct = 84;

        // Directed part under the reset memory size.
        send_item(MODE_BAD_LO, 4'd0, '0, '0);
        send_item(MODE_BAD_HI, 4'd15, ALL_ONES, ALL_ONES);
        send_item(MODE_CALL, 4'd0, 64'h1000, 64'h2000);       // sp wraps below zero
        send_item(MODE_RET, 4'd0, '0, '0);                    // failed load gives pc 0
        send_item(MODE_LOAD, SP_IDX, 64'd4096, '0);
        send_item(MODE_PUSH, SP_IDX, '0, 64'h40);              // stores the decremented sp
        send_item(MODE_POP, SP_IDX, '0, 64'h48);               // sp ends at old sp + 8
        send_item(MODE_LOAD, 4'd0, ALL_ONES, '0);
        send_item(MODE_LOAD, 4'd14, 64'h8000_0000_0000_0001, ALL_ONES);
        send_item(MODE_LOAD, SP_IDX, 64'd11, '0);
        send_item(MODE_PUSH, 4'd0, '0, ALL_ONES);              // unaligned store
        send_item(MODE_POP, 4'd15, '0, '0);
        send_item(MODE_PUSH, 4'd15, '0, 64'h10);               // register 15 reads as zero
        send_item(MODE_LOAD, 4'd15, 64'hDEAD_BEEF_0BAD_F00D, '0);
        send_item(MODE_PUSH, 4'd14, '0, 64'h18);
        send_item(MODE_POP, 4'd1, '0, 64'h20);
        send_item(MODE_CALL, 4'd0, ALL_ONES, 64'h0123_4567_89AB_CDEF);
        send_item(MODE_RET, 4'd0, '0, '0);
        send_item(MODE_LOAD, SP_IDX, 64'd4089, '0);
        send_item(MODE_POP, 4'd2, '0, 64'h30);                 // one byte past the end
        send_item(MODE_LOAD, SP_IDX, 64'hFFFF_FFFF_FFFF_FFFC, '0);
        send_item(MODE_POP, 4'd3, '0, 64'h38);                 // address near the top
        send_item(MODE_PUSH, 4'd1, '0, '0);
        send_item(MODE_LOAD, SP_IDX, 64'd8, '0);
        send_item(MODE_CALL, 4'd0, '0, ALL_ONES);              // store at address zero
        send_item(MODE_RET, 4'd0, '0, '0);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                snd_idle_pct = 84;
                rcv_idle_pct = 37;
            end else if (seg == 4) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_mem_size(mem_size_plan[seg]);
            seg_items = 0;
            while (seg_items < SEG_ITEMS) begin
                if ($urandom_range(3) == 0)
                    send_item(3'($urandom_range(7)), 4'($urandom_range(15)), rand64(), rand64());
                else
                    run_stack_program();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d instructions and checked %0d results over %0d memory size settings.",
                 items_sent, checked, cfg_writes + 1);
        $display("Stack programs and random opcodes ran under both stall patterns and none.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sui_pkg.sv
rtl/core/sui_front.sv
rtl/core/sui_mem.sv
rtl/core/sui_back.sv
rtl/core/stack_instruction_unit_core.sv
tb/stack_instruction_unit_checker.sv
tb/stack_instruction_unit_core_tb.sv
